### rtl/dbcr_pkg.sv
// ----------------------------------------------------------------------------
// dbcr_pkg
// Shared types and constants of the dark blob centroid and radius block.
// ----------------------------------------------------------------------------
package dbcr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Coordinate widths follow the largest frame.
    localparam int X_W = $clog2(MAX_WIDTH);
    localparam int Y_W = $clog2(MAX_HEIGHT);

    // Field widths of the ports.
    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CENTER_W   = 10;
    localparam int RAD_W      = 9;

    // Accumulator widths.
    localparam int CNT_W = X_W + Y_W + 1;
    localparam int SUM_W = X_W + Y_W + ((X_W > Y_W) ? X_W : Y_W);

    // Divider: the mean of coordinates is below 2**Q_W.
    localparam int Q_W    = (X_W > Y_W) ? X_W : Y_W;
    localparam int DIVR_W = CNT_W + Q_W - 1;
    localparam int DIV_W  = (SUM_W > DIVR_W) ? SUM_W : DIVR_W;
    localparam int STEP_W = $clog2(Q_W);

    localparam logic [PIX_W-1:0]  THRESHOLD_RESET = PIX_W'(50);
    localparam logic [SIZE_W-1:0] WIDTH_RESET     = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET    = SIZE_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_FIN
    } dbcr_state_t;

    typedef struct packed {
        logic accept;      // take the pixel and update the sums
        logic start_div;   // latch frame totals, clear sums
        logic div_step;    // one quotient bit
        logic load_pixel;  // plain pixel result into the output register
        logic load_frame;  // frame summary into the output register
    } dbcr_cmd_t;

    typedef struct packed {
        logic last_pixel;  // current position is the frame's last pixel
        logic out_free;    // output register can take an item
    } dbcr_status_t;

endpackage

### rtl/dbcr_if.sv
// ----------------------------------------------------------------------------
// dbcr_if
// Channel interfaces: pixel input, result output and register writes.
// ----------------------------------------------------------------------------
interface dbcr_pix_if
    import dbcr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface dbcr_res_if
    import dbcr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                marked;
    logic                frame_done;
    logic                found;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RAD_W-1:0]    radius;

    modport source (output valid, output marked, output frame_done, output found,
                    output center_x, output center_y, output radius, input ready);
    modport sink   (input valid, input marked, input frame_done, input found,
                    input center_x, input center_y, input radius, output ready);
endinterface

interface dbcr_cfg_if
    import dbcr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/dbcr_ctrl.sv
// ----------------------------------------------------------------------------
// dbcr_ctrl
// Sequencer: pixel acceptance, frame-end division and summary output.
// ----------------------------------------------------------------------------
module dbcr_ctrl
    import dbcr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  dbcr_status_t status,
    output dbcr_cmd_t    cmd
);

    dbcr_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_RUN:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.accept = 1'b1;
                    if (status.last_pixel)
                    begin
                        cmd.start_div = 1'b1;
                        step_next     = STEP_W'(Q_W - 1);
                        state_next    = ST_DIV;
                    end
                    else
                    begin
                        cmd.load_pixel = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == '0)
                    state_next = ST_FIN;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_FIN:
            begin
                // hold until the output register drains
                if (status.out_free)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

### rtl/dbcr_datapath.sv
// ----------------------------------------------------------------------------
// dbcr_datapath
// Position tracking, accumulators, shared restoring divider, output register.
// ----------------------------------------------------------------------------
module dbcr_datapath
    import dbcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PIX_W-1:0]  pixel_value,
    dbcr_cfg_if.sink          cfg,
    dbcr_res_if.source        res,
    input  dbcr_cmd_t         cmd,
    output dbcr_status_t      status
);

    // configuration
    logic [PIX_W-1:0]  threshold_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // frame accumulators
    logic [X_W-1:0]   column_reg, column_next;
    logic [Y_W-1:0]   row_reg, row_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [X_W-1:0]   min_x_reg, min_x_next, max_x_reg, max_x_next;
    logic [Y_W-1:0]   min_y_reg, min_y_next, max_y_reg, max_y_next;

    // frame-end divider and latched totals
    logic [DIV_W-1:0] rem_x_reg, rem_y_reg, divisor_reg;
    logic [Q_W-1:0]   quot_x_reg, quot_y_reg;
    logic             found_reg;
    logic             last_mark_reg;
    logic [X_W-1:0]   box_min_x_reg, box_max_x_reg;
    logic [Y_W-1:0]   box_min_y_reg, box_max_y_reg;

    // output register
    logic                out_valid_reg;
    logic                out_marked_reg, out_done_reg, out_found_reg;
    logic [CENTER_W-1:0] out_cx_reg, out_cy_reg;
    logic [RAD_W-1:0]    out_rad_reg;

    logic           mark;
    logic [X_W-1:0] limit_x;
    logic [Y_W-1:0] limit_y;
    logic           row_end;
    logic           ge_x, ge_y;
    logic [X_W-1:0] dx;
    logic [Y_W-1:0] dy;
    logic [Q_W-1:0] side_min;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_THRESHOLD:    threshold_reg <= cfg.data[PIX_W-1:0];
                REG_FRAME_WIDTH:  width_reg     <= cfg.data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg    <= cfg.data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    // last column and row; zero size acts as one, oversize as the maximum
    always_comb
    begin
        if (width_reg == '0)
            limit_x = '0;
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            limit_x = X_W'(MAX_WIDTH - 1);
        else
            limit_x = X_W'(width_reg - 1'b1);
        if (height_reg == '0)
            limit_y = '0;
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            limit_y = Y_W'(MAX_HEIGHT - 1);
        else
            limit_y = Y_W'(height_reg - 1'b1);
    end

    assign mark    = pixel_value < threshold_reg;
    assign row_end = column_reg >= limit_x;

    assign status.last_pixel = row_end && (row_reg >= limit_y);
    assign status.out_free   = !out_valid_reg || res.ready;

    always_comb
    begin
        count_next = count_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        min_x_next = min_x_reg;
        max_x_next = max_x_reg;
        min_y_next = min_y_reg;
        max_y_next = max_y_reg;
        if (mark)
        begin
            count_next = count_reg + 1'b1;
            sum_x_next = sum_x_reg + SUM_W'(column_reg);
            sum_y_next = sum_y_reg + SUM_W'(row_reg);
            if (column_reg < min_x_reg) min_x_next = column_reg;
            if (column_reg > max_x_reg) max_x_next = column_reg;
            if (row_reg < min_y_reg)    min_y_next = row_reg;
            if (row_reg > max_y_reg)    max_y_next = row_reg;
        end
        if (row_end)
        begin
            column_next = '0;
            row_next    = status.last_pixel ? '0 : row_reg + 1'b1;
        end
        else
        begin
            column_next = column_reg + 1'b1;
            row_next    = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            min_x_reg  <= '1;
            max_x_reg  <= '0;
            min_y_reg  <= '1;
            max_y_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            if (cmd.start_div)
            begin
                // clear for the next frame
                count_reg <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                min_x_reg <= '1;
                max_x_reg <= '0;
                min_y_reg <= '1;
                max_y_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                min_x_reg <= min_x_next;
                max_x_reg <= max_x_next;
                min_y_reg <= min_y_next;
                max_y_reg <= max_y_next;
            end
        end
    end

    assign ge_x = rem_x_reg >= divisor_reg;
    assign ge_y = rem_y_reg >= divisor_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            rem_x_reg     <= DIV_W'(sum_x_next);
            rem_y_reg     <= DIV_W'(sum_y_next);
            divisor_reg   <= DIV_W'({count_next, {(Q_W-1){1'b0}}});
            quot_x_reg    <= '0;
            quot_y_reg    <= '0;
            found_reg     <= count_next != '0;
            last_mark_reg <= mark;
            box_min_x_reg <= min_x_next;
            box_max_x_reg <= max_x_next;
            box_min_y_reg <= min_y_next;
            box_max_y_reg <= max_y_next;
        end
        else if (cmd.div_step)
        begin
            // one quotient bit per cycle, divisor walks right
            if (ge_x) rem_x_reg <= rem_x_reg - divisor_reg;
            if (ge_y) rem_y_reg <= rem_y_reg - divisor_reg;
            quot_x_reg  <= {quot_x_reg[Q_W-2:0], ge_x};
            quot_y_reg  <= {quot_y_reg[Q_W-2:0], ge_y};
            divisor_reg <= divisor_reg >> 1;
        end
    end

    assign dx       = box_max_x_reg - box_min_x_reg;
    assign dy       = box_max_y_reg - box_min_y_reg;
    assign side_min = (Q_W'(dx) < Q_W'(dy)) ? Q_W'(dx) : Q_W'(dy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_pixel || cmd.load_frame)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            out_marked_reg <= mark;
            out_done_reg   <= 1'b0;
            out_found_reg  <= 1'b0;
            out_cx_reg     <= '0;
            out_cy_reg     <= '0;
            out_rad_reg    <= '0;
        end
        else if (cmd.load_frame)
        begin
            out_marked_reg <= last_mark_reg;
            out_done_reg   <= 1'b1;
            out_found_reg  <= found_reg;
            out_cx_reg     <= found_reg ? CENTER_W'(quot_x_reg) : '0;
            out_cy_reg     <= found_reg ? CENTER_W'(quot_y_reg) : '0;
            out_rad_reg    <= found_reg ? RAD_W'(side_min >> 1) : '0;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.marked     = out_marked_reg;
    assign res.frame_done = out_done_reg;
    assign res.found      = out_found_reg;
    assign res.center_x   = out_cx_reg;
    assign res.center_y   = out_cy_reg;
    assign res.radius     = out_rad_reg;

endmodule

### rtl/dark_blob_centroid_radius.sv
// ----------------------------------------------------------------------------
// dark_blob_centroid_radius
// Thresholded blob centroid and radius over a raster pixel stream.
// ----------------------------------------------------------------------------
// Each pixel item yields one result item. Pixels are taken one per cycle while
// the output register is free; after the last pixel of a frame the input is held
// while the restoring divider forms both centroid quotients one bit per cycle,
// before the frame summary is loaded into the output register. Position and
// sums advance only on accepted pixels; register writes are taken at any
// time and do not move the position or clear the sums.
module dark_blob_centroid_radius
    import dbcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dbcr_pix_if.sink   pixels,
    dbcr_res_if.source results,
    dbcr_cfg_if.sink   cfg
);

    dbcr_cmd_t    cmd;
    dbcr_status_t status;
    logic         in_ready;

    assign pixels.ready = in_ready;

    dbcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dbcr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_value (pixels.pixel_value),
        .cfg         (cfg),
        .res         (results),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

### verif/blob_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_checker
// Watches the pixel, result and register channels of the dark blob block.
// Keeps its own copy of the frame position, sums and bounding box, predicts
// one report per pixel item and compares every result item field by field.
// ----------------------------------------------------------------------------
module blob_checker
    import dbcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dbcr_pix_if  pixels,
    dbcr_res_if  results,
    dbcr_cfg_if  cfg,
    output int   failures,
    output int   outstanding
);

    typedef struct packed {
        logic                marked;
        logic                frame_done;
        logic                found;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [RAD_W-1:0]    radius;
    } blob_report_t;

    blob_report_t blob_reports[$];
    blob_report_t oldest_report;

    logic [PIX_W-1:0]  threshold;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;

    logic [X_W-1:0]   column;
    logic [Y_W-1:0]   row;
    logic [CNT_W-1:0] marked_count;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [X_W-1:0]   min_x;
    logic [X_W-1:0]   max_x;
    logic [Y_W-1:0]   min_y;
    logic [Y_W-1:0]   max_y;

    int error_count;

    // A size of zero acts as one, anything above the maximum as the maximum.
    function automatic int clamp_size(input logic [SIZE_W-1:0] value, input int limit);
        if (value == '0)
            return 1;
        if (int'(value) > limit)
            return limit;
        return int'(value);
    endfunction

    task automatic clear_frame();
        column       = '0;
        row          = '0;
        marked_count = '0;
        sum_x        = '0;
        sum_y        = '0;
        min_x        = '1;
        max_x        = '0;
        min_y        = '1;
        max_y        = '0;
    endtask

    task automatic predict_blob_report(input logic [PIX_W-1:0] pix);
        blob_report_t     rep;
        int               fw;
        int               fh;
        int               dx;
        int               dy;
        logic [SUM_W-1:0] quot_x;
        logic [SUM_W-1:0] quot_y;
        fw  = clamp_size(frame_width, MAX_WIDTH);
        fh  = clamp_size(frame_height, MAX_HEIGHT);
        rep = '0;
        rep.marked = (pix < threshold);
        if (rep.marked)
        begin
            marked_count = marked_count + 1'b1;
            sum_x        = sum_x + SUM_W'(column);
            sum_y        = sum_y + SUM_W'(row);
            if (column > max_x) max_x = column;
            if (column < min_x) min_x = column;
            if (row > max_y) max_y = row;
            if (row < min_y) min_y = row;
        end
        // Compare with >= so a size shrunk mid-frame still wraps the position.
        if (int'(column) >= fw - 1)
        begin
            column = '0;
            if (int'(row) >= fh - 1)
            begin
                rep.frame_done = 1'b1;
                row            = '0;
            end
            else
            begin
                row = row + 1'b1;
            end
        end
        else
        begin
            column = column + 1'b1;
        end
        if (rep.frame_done)
        begin
            if (marked_count != '0)
            begin
                dx           = int'(max_x) - int'(min_x);
                dy           = int'(max_y) - int'(min_y);
                quot_x       = sum_x / marked_count;
                quot_y       = sum_y / marked_count;
                rep.found    = 1'b1;
                rep.center_x = quot_x[CENTER_W-1:0];
                rep.center_y = quot_y[CENTER_W-1:0];
                rep.radius   = RAD_W'(((dx < dy) ? dx : dy) / 2);
            end
            clear_frame();
        end
        blob_reports.push_back(rep);
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold    = THRESHOLD_RESET;
            frame_width  = WIDTH_RESET;
            frame_height = HEIGHT_RESET;
            clear_frame();
            blob_reports.delete();
            error_count  = 0;
            failures    <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_THRESHOLD:    threshold    = cfg.data[PIX_W-1:0];
                    REG_FRAME_WIDTH:  frame_width  = cfg.data[SIZE_W-1:0];
                    REG_FRAME_HEIGHT: frame_height = cfg.data[SIZE_W-1:0];
                    default:          ;
                endcase
            end
            if (pixels.valid && pixels.ready)
                predict_blob_report(pixels.pixel_value);
            if (results.valid && results.ready)
            begin
                if (blob_reports.size() == 0)
                begin
                    $error("result item with no pixel item waiting");
                    error_count++;
                end
                else
                begin
                    oldest_report = blob_reports.pop_front();
                    check_field("marked", oldest_report.marked, results.marked);
                    check_field("frame_done", oldest_report.frame_done, results.frame_done);
                    check_field("found", oldest_report.found, results.found);
                    check_field("center_x", oldest_report.center_x, results.center_x);
                    check_field("center_y", oldest_report.center_y, results.center_y);
                    check_field("radius", oldest_report.radius, results.radius);
                end
            end
            failures    <= error_count;
            outstanding <= blob_reports.size();
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the dark blob centroid and radius block: a directed pass over
// thresholds, degenerate frame sizes and a small known frame, then frames of
// random size holding random dark rectangles plus noise, with random idling
// on both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import dbcr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);
    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1600;

    logic clk;
    logic rst_n;
    logic quiet;
    int   failures;
    int   outstanding;
    int   stall_cycles = 0;
    int   pixels_sent;

    dbcr_pix_if pixels ();
    dbcr_res_if results ();
    dbcr_cfg_if cfg ();

    dark_blob_centroid_radius dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .results (results),
        .cfg     (cfg)
    );

    blob_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pixels),
        .results     (results),
        .cfg         (cfg),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        results.ready <= quiet || ($urandom_range(99) >= 29);

    // End the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (pixels.valid && pixels.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        if (!quiet)
        begin
            while ($urandom_range(99) < 29)
            begin
                pixels.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pixels.valid       <= 1'b1;
        pixels.pixel_value <= value;
        @(posedge clk);
        while (!pixels.ready) @(posedge clk);
    endtask

    // Hold the pixel stream until every report is out, then write one register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        pixels.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Stream frames with one dark rectangle at a random place, plus noise.
    task automatic feed_blob(input int thr, input int fw, input int fh, input int count);
        int x0;
        int x1;
        int y0;
        int y1;
        int x;
        int y;
        int v;
        int i;
        x0 = $urandom_range(fw - 1, 0);
        x1 = $urandom_range(fw - 1, x0);
        y0 = $urandom_range(fh - 1, 0);
        y1 = $urandom_range(fh - 1, y0);
        x  = 0;
        y  = 0;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                v = $urandom_range(255, 0);
            else if (thr > 0 && x >= x0 && x <= x1 && y >= y0 && y <= y1)
                v = $urandom_range(thr - 1, 0);
            else
                v = $urandom_range(255, thr);
            send_pixel(v[PIX_W-1:0]);
            x++;
            if (x >= fw)
            begin
                x = 0;
                y++;
                if (y >= fh) y = 0;
            end
        end
        pixels_sent += count;
    endtask

    initial
    begin
        int thr;
        int w;
        int h;
        int fw;
        int fh;
        int n;
        rst_n              <= 1'b0;
        quiet              <= 1'b0;
        pixels.valid       <= 1'b0;
        pixels.pixel_value <= '0;
        cfg.valid          <= 1'b0;
        cfg.index          <= REG_THRESHOLD;
        cfg.data           <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero sizes act as one: every pixel closes a frame.
        write_reg(REG_FRAME_WIDTH, 0);
        write_reg(REG_FRAME_HEIGHT, 0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd49);
        send_pixel(8'd50);
        write_reg(REG_THRESHOLD, 0);
        send_pixel(8'd0);
        // Upper data bits are dropped, leaving the top threshold.
        write_reg(REG_THRESHOLD, 11'h7FF);
        send_pixel(8'd254);
        send_pixel(8'd255);
        // Unused register index: threshold must stay put.
        write_reg(REG_NONE, 11'h0AA);
        send_pixel(8'd254);

        // Small known frame with dark corners.
        write_reg(REG_THRESHOLD, 128);
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        send_pixel(8'd0);
        send_pixel(8'd200);
        send_pixel(8'd10);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd5);

        pixels_sent = 0;

        // One full row at the widest clamped size, with no idling.
        quiet <= 1'b1;
        thr = $urandom_range(255, 1);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FRAME_WIDTH, 11'h7FF);
        write_reg(REG_FRAME_HEIGHT, 1);
        feed_blob(thr, MAX_WIDTH, 1, MAX_WIDTH);
        quiet <= 1'b0;

        // A tall frame left unfinished; later sizes shrink it mid-frame.
        thr = $urandom_range(255, 1);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FRAME_WIDTH, 1);
        write_reg(REG_FRAME_HEIGHT, 11'h7FF);
        feed_blob(thr, 1, MAX_HEIGHT, 120);
        write_reg(REG_FRAME_HEIGHT, MAX_HEIGHT);
        feed_blob(thr, 1, MAX_HEIGHT, 40);

        while (pixels_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0:       thr = 0;
                1:       thr = 255;
                default: thr = $urandom_range(255, 0);
            endcase
            w = $urandom_range(8, 1);
            h = $urandom_range(8, 1);
            if ($urandom_range(9) == 0) w = 0;
            if ($urandom_range(9) == 0) h = 0;
            write_reg(REG_THRESHOLD, thr + ($urandom_range(7) << 8));
            write_reg(REG_FRAME_WIDTH, w);
            write_reg(REG_FRAME_HEIGHT, h);
            fw = (w == 0) ? 1 : w;
            fh = (h == 0) ? 1 : h;
            n  = fw * fh * $urandom_range(4, 1);
            // Break off now and then in the middle of a frame.
            if ($urandom_range(4) == 0) n = $urandom_range(fw * fh, 1);
            feed_blob(thr, fw, fh, n);
        end

        pixels.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### dark_blob_centroid_radius.f
rtl/dbcr_pkg.sv
rtl/dbcr_if.sv
rtl/dbcr_ctrl.sv
rtl/dbcr_datapath.sv
rtl/dark_blob_centroid_radius.sv
verif/blob_checker.sv
verif/tb_top.sv
